@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL. Every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define CPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cpf_pkg.sv @@
`default_nettype none

package cpf_pkg;

    localparam int NUM_PARAM_FIELDS = 5;
    localparam int POS_W            = 5;
    localparam int CNT_W            = 3;

    // Fixed byte positions inside a packet
    localparam logic [POS_W-1:0] POS_HDR_HI  = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR_LO  = 5'd1;
    localparam logic [POS_W-1:0] POS_ADDR_3  = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR_2  = 5'd3;
    localparam logic [POS_W-1:0] POS_ADDR_1  = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR_0  = 5'd5;
    localparam logic [POS_W-1:0] POS_KIND    = 5'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd8;
    localparam logic [POS_W-1:0] POS_OPCODE  = 5'd9;
    localparam logic [POS_W-1:0] POS_PARAM0  = 5'd10;

    // Length field counts opcode and the two checksum bytes on top of params
    localparam logic [7:0] LEN_BIAS = 8'd3;

    // Register indexes on the config port
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_ADDR   = 2'd1;
    localparam logic [1:0] REG_KIND   = 2'd2;

    // Register reset values
    localparam logic [15:0] HEADER_RST = 16'hEF01;
    localparam logic [31:0] ADDR_RST   = 32'hFFFF_FFFF;
    localparam logic [7:0]  KIND_RST   = 8'h01;

    typedef logic [NUM_PARAM_FIELDS-1:0][7:0] param_vec_t;

    // Per-position flags from the byte selector
    typedef struct packed {
        logic summed;   // byte goes into the checksum
        logic sum_hi;   // high checksum byte
        logic final_b;  // low checksum byte, ends the packet
    } cpf_sel_t;

endpackage

`default_nettype wire

@@ hw/rtl/cpf_byte_mux.sv @@
`default_nettype none

module cpf_byte_mux (
    input  wire logic [4:0]          pos,
    input  wire logic [15:0]         header_word,
    input  wire logic [31:0]         device_address,
    input  wire logic [7:0]          packet_kind,
    input  wire logic [7:0]          opcode,
    input  wire logic [2:0]          count,
    input  wire cpf_pkg::param_vec_t params,
    input  wire logic [15:0]         sum,
    output logic [7:0]               data,
    output cpf_pkg::cpf_sel_t        sel
);
    import cpf_pkg::*;

    logic [POS_W-1:0] param_end;
    logic [POS_W-1:0] pdiff;
    logic [CNT_W-1:0] pidx;
    logic [7:0]       length;

    assign param_end = POS_PARAM0 + {2'b00, count};
    assign pdiff     = pos - POS_PARAM0;
    assign pidx      = pdiff[CNT_W-1:0];
    assign length    = {5'b00000, count} + LEN_BIAS;

    always_comb
    begin
        data = 8'h00;
        sel  = '0;
        priority if (pos < POS_PARAM0)
        begin
            unique case (pos)
                POS_HDR_HI: data = header_word[15:8];
                POS_HDR_LO: data = header_word[7:0];
                POS_ADDR_3: data = device_address[31:24];
                POS_ADDR_2: data = device_address[23:16];
                POS_ADDR_1: data = device_address[15:8];
                POS_ADDR_0: data = device_address[7:0];
                POS_KIND:
                begin
                    data       = packet_kind;
                    sel.summed = 1'b1;
                end
                POS_LEN_HI:
                begin
                    data       = 8'h00;
                    sel.summed = 1'b1;
                end
                POS_LEN_LO:
                begin
                    data       = length;
                    sel.summed = 1'b1;
                end
                POS_OPCODE:
                begin
                    data       = opcode;
                    sel.summed = 1'b1;
                end
                default: data = 8'h00;
            endcase
        end
        else if (pos < param_end)
        begin
            if (pidx < 3'(NUM_PARAM_FIELDS))
                data = params[pidx];
            sel.summed = 1'b1;
        end
        else if (pos == param_end)
        begin
            data       = sum[15:8];
            sel.sum_hi = 1'b1;
        end
        else
        begin
            data        = sum[7:0];
            sel.final_b = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/command_packet_framer_unit.sv @@
// Command packet framer.
// Input channel (in_valid / in_stall): one request carries an opcode, a
// parameter count and five parameter bytes. Counts above the limit are
// clamped; parameter fields past the count are ignored.
// Output channel (out_valid / out_stall): the packet leaves one byte per
// request: header (2), address (4), kind, length (2), opcode, parameters,
// then the 16-bit checksum high byte first; last_byte marks the final byte.
// After the input request is taken, the sequencer enters its send state
// and then loads the first byte into the output register; 12 + count
// bytes then stream one byte per cycle while the output does not stall.
// The byte sequencer walks the packet one position per cycle unless the
// output stalls, and feeds a single 16-bit accumulator for the checksum.
// in_stall is high while a packet is being walked; the next command is
// taken as soon as the last byte has been loaded into the output register.
// A stall on the output freezes the sequencer and holds the output byte.
// Reset clears the sequencer and output valid, and returns the header,
// address and kind registers to EF01, FFFFFFFF and 01. Config writes
// (cfg_we, cfg_index, cfg_data) are registered; index 3 is ignored.
`default_nettype none

`include "assert_macros.svh"

module command_packet_framer_unit #(
    parameter int MAX_PARAMS = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  opcode,
    input  wire logic [2:0]  param_count,
    input  wire logic [7:0]  param_0,
    input  wire logic [7:0]  param_1,
    input  wire logic [7:0]  param_2,
    input  wire logic [7:0]  param_3,
    input  wire logic [7:0]  param_4,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);
    import cpf_pkg::*;

    localparam int LIMIT = (MAX_PARAMS < NUM_PARAM_FIELDS) ? MAX_PARAMS : NUM_PARAM_FIELDS;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    // Config registers
    logic [15:0] header_reg;
    logic [31:0] addr_reg;
    logic [7:0]  kind_reg;

    // Sequencer and held command
    logic             state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       opcode_reg;
    logic [CNT_W-1:0] count_reg;
    param_vec_t       params_reg;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;

    logic [CNT_W-1:0] count_clamped;
    logic             in_take;
    logic             load;
    logic [7:0]       sel_byte;
    cpf_sel_t         sel;
    logic [POS_W-1:0] last_pos;

    assign count_clamped = (param_count > LIMIT_C) ? LIMIT_C : param_count;
    assign in_take       = in_valid && (state_reg == ST_IDLE);
    assign load          = (state_reg == ST_SEND) && (!out_valid_reg || !out_stall);
    assign last_pos      = POS_PARAM0 + {2'b00, count_reg} + 5'd1;

    assign in_stall  = (state_reg == ST_SEND);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

    cpf_byte_mux u_mux (
        .pos            (pos_reg),
        .header_word    (header_reg),
        .device_address (addr_reg),
        .packet_kind    (kind_reg),
        .opcode         (opcode_reg),
        .count          (count_reg),
        .params         (params_reg),
        .sum            (sum_reg),
        .data           (sel_byte),
        .sel            (sel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            addr_reg   <= ADDR_RST;
            kind_reg   <= KIND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER: header_reg <= cfg_data[15:0];
                REG_ADDR:   addr_reg   <= cfg_data;
                REG_KIND:   kind_reg   <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Sequencer: one packet position per cycle unless the output stalls, checksum accumulated in place
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEND;
                    pos_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_SEND:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + 5'd1;
                    if (sel.summed)
                        sum_next = sum_reg + {8'h00, sel_byte};
                    if (sel.final_b)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            opcode_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (in_take)
            begin
                opcode_reg <= opcode;
                count_reg  <= count_clamped;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            params_reg <= {param_4, param_3, param_2, param_1, param_0};
        if (load)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= sel.final_b;
        end
    end

    `CPF_ASSERT(a_count_limit, count_reg <= LIMIT_C, "held count above limit")
    `CPF_ASSERT_IMP(a_pos_range, state_reg == ST_SEND, pos_reg <= last_pos,
                    "position past packet")
    `CPF_ASSERT_IMP(a_sum_hi_busy, sel.sum_hi, state_reg == ST_SEND,
                    "checksum byte selected while idle")
    `CPF_ASSERT_NXT(a_take_start, in_take,
                    state_reg == ST_SEND && pos_reg == '0 && sum_reg == '0,
                    "bad packet start")
    `CPF_ASSERT_NXT(a_final_done, load && sel.final_b,
                    state_reg == ST_IDLE && last_reg && out_valid_reg,
                    "packet end not closed")

endmodule

`default_nettype wire
